>>> hdl/sorted_range_list_union_core_defines.svh
// Assertion macros shared by the checker of the range list merger.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef SORTED_RANGE_LIST_UNION_CORE_DEFINES_SVH
`define SORTED_RANGE_LIST_UNION_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRLU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srlu assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRLU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srlu assertion failed");

`endif

>>> hdl/srlu_pkg.sv
package srlu_pkg;

  // Width of one range id.
  localparam int unsigned ID_W = 31;

  // Default number of ranges each list can hold.
  localparam int unsigned LIST_DEPTH = 32;

  // Request opcodes.
  localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [1:0] OP_MERGE         = 2'd2;

  // One half-open range [lo, hi).
  typedef struct packed {
    logic [ID_W-1:0] lo;
    logic [ID_W-1:0] hi;
  } span_t;

endpackage

>>> hdl/srlu_channels.sv
// Request channel: one opcode with an optional range per beat.
interface srlu_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic [srlu_pkg::ID_W-1:0]   range_start;
  logic [srlu_pkg::ID_W-1:0]   range_end;

  modport source (output valid, output opcode, output range_start, output range_end,
                  input ready);
  modport sink   (input valid, input opcode, input range_start, input range_end,
                  output ready);
endinterface

// Response channel: one merged range per beat.
interface srlu_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [srlu_pkg::ID_W-1:0]   out_start;
  logic [srlu_pkg::ID_W-1:0]   out_end;
  logic                        last;
  logic                        no_ranges;
  logic                        overflowed;

  modport source (output valid, output out_start, output out_end, output last,
                  output no_ranges, output overflowed, input ready);
  modport sink   (input valid, input out_start, input out_end, input last,
                  input no_ranges, input overflowed, output ready);
endinterface

>>> hdl/srlu_list_ram.sv
// Single-port-write, single-port-read list storage with registered read data.
module srlu_list_ram #(
  parameter int unsigned DEPTH = srlu_pkg::LIST_DEPTH
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  srlu_pkg::span_t                              wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output srlu_pkg::span_t                              rd_data
);

  srlu_pkg::span_t mem [DEPTH];

  // Write on append; read data is registered and holds when idle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/sorted_range_list_union_core.sv
// Appends and ignored opcodes leave the block idle; the block is ready again on the next cycle.
// A merge walks the lists with two pointers; each step passes S_READ (memory read), then S_CMP
// (compare), and S_FINAL emits the final range; the memories' registered read data sets that pace.
// A merge of two empty lists goes straight to S_FINAL and emits a single beat.
// Output beats stall the walk while the output register is full and not taken.
// Synchronous reset empties both lists and clears the overflow flag, the state and the valid flags.
module sorted_range_list_union_core #(
  parameter int unsigned LIST_DEPTH = srlu_pkg::LIST_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  srlu_req_if.sink       req,
  srlu_rsp_if.source     rsp
);

  localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_FINAL
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] first_count;
  logic [CNT_W-1:0] second_count;
  logic             dropped_flag;
  logic [CNT_W-1:0] idx_a;
  logic [CNT_W-1:0] idx_b;
  logic             plain;
  logic             none;
  logic             pend_v;
  srlu_pkg::span_t  pend;

  // Output register.
  logic             out_valid;
  srlu_pkg::span_t  out_span;
  logic             out_last;
  logic             out_none;
  logic             out_ovf;

  // Memory ports.
  logic             wr_a;
  logic             wr_b;
  logic             rd_en;
  srlu_pkg::span_t  wr_span;
  srlu_pkg::span_t  rd_a;
  srlu_pkg::span_t  rd_b;

  logic             accept;
  logic             can_emit;
  logic             load_out;

  // Walk step signals.
  logic             have_a;
  logic             have_b;
  logic             adv_a;
  logic             adv_b;
  srlu_pkg::span_t  taken;
  logic             need_emit;
  logic [CNT_W-1:0] idx_a_next;
  logic [CNT_W-1:0] idx_b_next;
  logic             more;

  assign accept   = req.valid && req.ready;
  assign can_emit = !out_valid || rsp.ready;
  assign load_out = can_emit && (((state == S_CMP) && need_emit) || (state == S_FINAL));

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.out_start  = out_span.lo;
  assign rsp.out_end    = out_span.hi;
  assign rsp.last       = out_last;
  assign rsp.no_ranges  = out_none;
  assign rsp.overflowed = out_ovf;

  // Appends write at the list's fill count; the walk never overlaps an append.
  assign wr_span.lo = req.range_start;
  assign wr_span.hi = req.range_end;
  assign wr_a  = accept && (req.opcode == srlu_pkg::OP_APPEND_FIRST) && (first_count < FULL);
  assign wr_b  = accept && (req.opcode == srlu_pkg::OP_APPEND_SECOND) && (second_count < FULL);
  assign rd_en = (state == S_READ);

  srlu_list_ram #(.DEPTH(LIST_DEPTH)) u_first_ram (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (first_count[IDX_W-1:0]),
    .wr_data (wr_span),
    .rd_en   (rd_en),
    .rd_addr (idx_a[IDX_W-1:0]),
    .rd_data (rd_a)
  );

  srlu_list_ram #(.DEPTH(LIST_DEPTH)) u_second_ram (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (second_count[IDX_W-1:0]),
    .wr_data (wr_span),
    .rd_en   (rd_en),
    .rd_addr (idx_b[IDX_W-1:0]),
    .rd_data (rd_b)
  );

  // Pick the next range from the two heads, as the two-pointer merge does.
  always_comb begin
    have_a = (idx_a < first_count);
    have_b = (idx_b < second_count);
    adv_a  = 1'b0;
    adv_b  = 1'b0;
    taken  = rd_b;
    if (have_a && have_b) begin
      if (rd_a.lo > rd_b.hi) begin
        taken = rd_b;
        adv_b = 1'b1;
      end else if (rd_a.hi < rd_b.lo) begin
        taken = rd_a;
        adv_a = 1'b1;
      end else begin
        taken.lo = (rd_a.lo < rd_b.lo) ? rd_a.lo : rd_b.lo;
        taken.hi = (rd_a.hi > rd_b.hi) ? rd_a.hi : rd_b.hi;
        adv_a    = 1'b1;
        adv_b    = 1'b1;
      end
    end else if (have_a) begin
      taken = rd_a;
      adv_a = 1'b1;
    end else begin
      taken = rd_b;
      adv_b = 1'b1;
    end
    idx_a_next = idx_a + CNT_W'(adv_a);
    idx_b_next = idx_b + CNT_W'(adv_b);
    more       = (idx_a_next < first_count) || (idx_b_next < second_count);
    // The pending run closes unless both lists hold ranges and the new range starts at its end.
    need_emit  = pend_v && (plain || (pend.hi != taken.lo));
  end

  // Control, list counts, pending run and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      first_count  <= '0;
      second_count <= '0;
      dropped_flag <= 1'b0;
      pend_v       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // The output register fills with a new beat and empties when its beat is taken.
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.opcode)
              srlu_pkg::OP_APPEND_FIRST: begin
                if (first_count < FULL) begin
                  first_count <= first_count + CNT_W'(1);
                end else begin
                  dropped_flag <= 1'b1;
                end
              end
              srlu_pkg::OP_APPEND_SECOND: begin
                if (second_count < FULL) begin
                  second_count <= second_count + CNT_W'(1);
                end else begin
                  dropped_flag <= 1'b1;
                end
              end
              srlu_pkg::OP_MERGE: begin
                idx_a  <= '0;
                idx_b  <= '0;
                pend_v <= 1'b0;
                plain  <= (first_count == '0) || (second_count == '0);
                none   <= (first_count == '0) && (second_count == '0);
                pend   <= '0;
                if ((first_count == '0) && (second_count == '0)) begin
                  state <= S_FINAL;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          // Hold the read data and stall while a closed run cannot be sent.
          if (!need_emit || can_emit) begin
            if (need_emit) begin
              out_span  <= pend;
              out_last  <= 1'b0;
              out_none  <= 1'b0;
              out_ovf   <= dropped_flag;
            end
            if (pend_v && !need_emit) begin
              pend.hi <= taken.hi;
            end else begin
              pend <= taken;
            end
            pend_v <= 1'b1;
            idx_a  <= idx_a_next;
            idx_b  <= idx_b_next;
            state  <= more ? S_READ : S_FINAL;
          end
        end
        S_FINAL: begin
          // Send the last run and clear the lists for the next round.
          if (can_emit) begin
            out_span     <= pend;
            out_last     <= 1'b1;
            out_none     <= none;
            out_ovf      <= dropped_flag;
            first_count  <= '0;
            second_count <= '0;
            dropped_flag <= 1'b0;
            pend_v       <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/srlu_checker.sv
`include "sorted_range_list_union_core_defines.svh"

// Port-level checks of the range list merger.
module srlu_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [1:0]                opcode,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [srlu_pkg::ID_W-1:0] out_start,
  input logic [srlu_pkg::ID_W-1:0] out_end,
  input logic                      last,
  input logic                      no_ranges
);

  // A stalled result beat keeps its payload.
  `SRLU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_start) && $stable(out_end) && $stable(last))

  // The empty-merge marker is always the final beat of its merge.
  `SRLU_ASSERT_SAME(a_none_last, out_valid && no_ranges, last)

  // The empty-merge marker carries a zero range.
  `SRLU_ASSERT_SAME(a_none_zero, out_valid && no_ranges, out_start == '0 && out_end == '0)

  // A merge beat closes the request channel while the lists are walked.
  `SRLU_ASSERT_NEXT(a_merge_busy, in_valid && in_ready && opcode == srlu_pkg::OP_MERGE, !in_ready)

endmodule

bind sorted_range_list_union_core srlu_checker u_srlu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .opcode    (req.opcode),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_start (rsp.out_start),
  .out_end   (rsp.out_end),
  .last      (rsp.last),
  .no_ranges (rsp.no_ranges)
);
